FILE: sv/keyed_count_table_with_purge_unit_assert.svh
// Assertion macros for the keyed count table with purge unit.
// Included by RTL files that carry concurrent checks; expects clk and rst_n in scope.
`ifndef KEYED_COUNT_TABLE_WITH_PURGE_UNIT_ASSERT_SVH
`define KEYED_COUNT_TABLE_WITH_PURGE_UNIT_ASSERT_SVH

`ifndef SYNTHESIS
// Same-cycle implication, disabled while reset is asserted.
`define KCPT_ASSERT(lbl, ant, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ant) |-> (cons)) \
    else $error("keyed count table: assertion failed");
// Next-cycle implication, disabled while reset is asserted.
`define KCPT_ASSERT_NXT(lbl, ant, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ant) |=> (cons)) \
    else $error("keyed count table: assertion failed");
`else
`define KCPT_ASSERT(lbl, ant, cons)
`define KCPT_ASSERT_NXT(lbl, ant, cons)
`endif

`endif

FILE: sv/kcpt_pkg.sv
// Shared types and constants of the keyed count table with purge unit.
// No dependencies.
`timescale 1ns / 1ps

package kcpt_pkg;

  localparam int TABLE_ENTRIES_DEF = 16;
  localparam int KEY_W             = 64;
  localparam int VAL_W             = 32;
  localparam int CNT_OUT_W         = 5;

  typedef enum logic {
    CMD_ADD   = 1'b0,
    CMD_PURGE = 1'b1
  } cmd_t;

  typedef enum logic [1:0] {
    STAT_ACCUM = 2'd0,
    STAT_NEW   = 2'd1,
    STAT_FULL  = 2'd2,
    STAT_PURGE = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SCAN,
    ST_FINISH
  } state_t;

  // One table slot as stored in memory.
  typedef struct packed {
    logic                    vld;
    logic [KEY_W-1:0]        key;
    logic signed [VAL_W-1:0] cnt;
  } ent_t;

endpackage

FILE: sv/keyed_count_table_with_purge_unit.sv
// Top level of the keyed count table with purge unit.
// Depends on kcpt_pkg, kcpt_ram and keyed_count_table_with_purge_unit_assert.svh.
`timescale 1ns / 1ps

// The unit keeps TABLE_ENTRIES slots, each holding a valid mark, a 64-bit key and a
// signed 32-bit count, all in one memory with a registered read. An add transaction
// (in_tuser low) adds its amount to the slot holding its key with signed saturation,
// or claims the lowest free slot, or reports the table as full. A purge transaction
// (in_tuser high) frees every valid slot whose count is below the signed threshold.
// Every input transaction produces exactly one output transaction. Each command is
// handled by a sequential walk over the memory, one slot read per cycle; the unit takes
// no new command until the walk is done and the previous result has been taken.
// After reset the unit clears every slot of the memory before it raises in_tready
// for the first time.
module keyed_count_table_with_purge_unit
  import kcpt_pkg::*;
#(
  parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [95:0] in_tdata,   // [63:0] song_key, [95:64] value
  input  logic        in_tuser,   // [0] cmd
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [47:0] out_tdata,  // [31:0] entry_total, [36:32] removed_count,
                                  // [41:37] occupied_count, [47:42] zero
  output logic [1:0]  out_tuser   // [1:0] status
);

`include "keyed_count_table_with_purge_unit_assert.svh"

  localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int CNT_W = IDX_W + 1;
  localparam int OCC_W = $clog2(TABLE_ENTRIES + 1);
  localparam int ENT_W = $bits(ent_t);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_ENTRIES - 1);

  // Control state.
  state_t           state_r, state_nxt;
  logic [CNT_W-1:0] rd_cnt_r, rd_cnt_nxt;     // next slot to read, or to clear
  logic             rd_vld_r, rd_vld_nxt;     // memory data this cycle belongs to a scan
  logic [IDX_W-1:0] rd_idx_r, rd_idx_nxt;     // slot whose data arrives this cycle
  logic [OCC_W-1:0] occ_r, occ_nxt;
  logic             out_valid_r, out_valid_nxt;

  // Command and scan results.
  cmd_t                    cmd_r, cmd_nxt;
  logic [KEY_W-1:0]        key_r, key_nxt;
  logic signed [VAL_W-1:0] val_r, val_nxt;
  logic                    found_r, found_nxt;
  logic [IDX_W-1:0]        hit_r, hit_nxt;
  logic signed [VAL_W-1:0] hit_cnt_r, hit_cnt_nxt;
  logic                    free_r, free_nxt;
  logic [IDX_W-1:0]        free_idx_r, free_idx_nxt;
  logic [OCC_W-1:0]        removed_r, removed_nxt;

  // Output register.
  logic [47:0] out_tdata_r, out_tdata_nxt;
  status_t     out_stat_r, out_stat_nxt;

  // Memory port.
  logic             ram_we;
  logic [IDX_W-1:0] ram_waddr;
  ent_t             ram_wdata;
  logic [IDX_W-1:0] ram_raddr;
  logic [ENT_W-1:0] ram_rdata;
  ent_t             rd_ent;

  logic                    in_acc;
  logic                    fin_go;
  logic                    scan_last;
  logic                    purge_hit;
  logic signed [VAL_W:0]   sum_wide;
  logic signed [VAL_W-1:0] sat_sum;
  logic signed [VAL_W-1:0] total;
  status_t                 fin_stat;

  kcpt_ram #(
    .WIDTH (ENT_W),
    .DEPTH (TABLE_ENTRIES)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign rd_ent     = ent_t'(ram_rdata);
  assign in_tready  = (state_r == ST_IDLE);
  assign in_acc     = in_tvalid && in_tready;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tuser  = out_stat_r;

  // The result can be loaded when the output register is empty or being emptied.
  assign fin_go    = !out_valid_r || out_tready;
  assign scan_last = rd_vld_r && (rd_idx_r == LAST_IDX);
  assign ram_raddr = rd_cnt_r[IDX_W-1:0];

  // A purge frees a valid slot whose count lies below the threshold.
  assign purge_hit = rd_vld_r && (cmd_r == CMD_PURGE) && rd_ent.vld && (rd_ent.cnt < val_r);

  // Saturating add: the sign bits disagree exactly when the sum left the range.
  assign sum_wide = {hit_cnt_r[VAL_W-1], hit_cnt_r} + {val_r[VAL_W-1], val_r};
  always_comb begin
    if (sum_wide[VAL_W] != sum_wide[VAL_W-1]) begin
      sat_sum = sum_wide[VAL_W] ? {1'b1, {(VAL_W-1){1'b0}}} : {1'b0, {(VAL_W-1){1'b1}}};
    end else begin
      sat_sum = sum_wide[VAL_W-1:0];
    end
  end

  always_comb begin
    priority if (cmd_r == CMD_PURGE) begin
      fin_stat = STAT_PURGE;
      total    = '0;
    end else if (found_r) begin
      fin_stat = STAT_ACCUM;
      total    = sat_sum;
    end else if (free_r) begin
      fin_stat = STAT_NEW;
      total    = val_r;
    end else begin
      fin_stat = STAT_FULL;
      total    = '0;
    end
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_CLEAR:  if (rd_cnt_r[IDX_W-1:0] == LAST_IDX) state_nxt = ST_IDLE;
      ST_IDLE:   if (in_acc) state_nxt = ST_SCAN;
      ST_SCAN:   if (scan_last) state_nxt = ST_FINISH;
      ST_FINISH: if (fin_go) state_nxt = ST_IDLE;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  // Datapath and outputs of the sequencer.
  always_comb begin
    rd_cnt_nxt    = rd_cnt_r;
    rd_vld_nxt    = 1'b0;
    rd_idx_nxt    = rd_idx_r;
    occ_nxt       = occ_r;
    out_valid_nxt = out_tready ? 1'b0 : out_valid_r;
    cmd_nxt       = cmd_r;
    key_nxt       = key_r;
    val_nxt       = val_r;
    found_nxt     = found_r;
    hit_nxt       = hit_r;
    hit_cnt_nxt   = hit_cnt_r;
    free_nxt      = free_r;
    free_idx_nxt  = free_idx_r;
    removed_nxt   = removed_r;
    out_tdata_nxt = out_tdata_r;
    out_stat_nxt  = out_stat_r;
    ram_we        = 1'b0;
    ram_waddr     = rd_idx_r;
    ram_wdata     = '0;

    unique case (state_r)
      ST_CLEAR: begin
        ram_we     = 1'b1;
        ram_waddr  = rd_cnt_r[IDX_W-1:0];
        rd_cnt_nxt = rd_cnt_r + 1'b1;
      end
      ST_IDLE: begin
        if (in_acc) begin
          cmd_nxt     = cmd_t'(in_tuser);
          key_nxt     = in_tdata[63:0];
          val_nxt     = in_tdata[95:64];
          found_nxt   = 1'b0;
          free_nxt    = 1'b0;
          removed_nxt = '0;
          rd_cnt_nxt  = '0;
        end
      end
      ST_SCAN: begin
        // Issue one read per cycle until every slot has been requested.
        if (rd_cnt_r < CNT_W'(TABLE_ENTRIES)) begin
          rd_vld_nxt = 1'b1;
          rd_idx_nxt = rd_cnt_r[IDX_W-1:0];
          rd_cnt_nxt = rd_cnt_r + 1'b1;
        end
        if (rd_vld_r && (cmd_r == CMD_ADD)) begin
          if (rd_ent.vld) begin
            if (!found_r && (rd_ent.key == key_r)) begin
              found_nxt   = 1'b1;
              hit_nxt     = rd_idx_r;
              hit_cnt_nxt = rd_ent.cnt;
            end
          end else if (!free_r) begin
            free_nxt     = 1'b1;
            free_idx_nxt = rd_idx_r;
          end
        end
        // The freed slot is written back while the next slot is being read.
        if (purge_hit) begin
          ram_we        = 1'b1;
          ram_waddr     = rd_idx_r;
          ram_wdata     = rd_ent;
          ram_wdata.vld = 1'b0;
          removed_nxt   = removed_r + 1'b1;
        end
      end
      ST_FINISH: begin
        if (fin_go) begin
          ram_wdata.vld = 1'b1;
          ram_wdata.key = key_r;
          ram_wdata.cnt = total;
          unique case (fin_stat)
            STAT_ACCUM: begin
              ram_we    = 1'b1;
              ram_waddr = hit_r;
            end
            STAT_NEW: begin
              ram_we    = 1'b1;
              ram_waddr = free_idx_r;
              occ_nxt   = occ_r + 1'b1;
            end
            STAT_PURGE: occ_nxt = occ_r - removed_r;
            STAT_FULL:  ram_we = 1'b0;
            default:    ram_we = 1'b0;
          endcase
          out_valid_nxt = 1'b1;
          out_stat_nxt  = fin_stat;
          out_tdata_nxt = {6'd0, CNT_OUT_W'(occ_nxt),
                           CNT_OUT_W'((cmd_r == CMD_PURGE) ? removed_r : '0), total};
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      rd_cnt_r    <= '0;
      rd_vld_r    <= 1'b0;
      occ_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      rd_cnt_r    <= rd_cnt_nxt;
      rd_vld_r    <= rd_vld_nxt;
      occ_r       <= occ_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rd_idx_r    <= rd_idx_nxt;
    cmd_r       <= cmd_nxt;
    key_r       <= key_nxt;
    val_r       <= val_nxt;
    found_r     <= found_nxt;
    hit_r       <= hit_nxt;
    hit_cnt_r   <= hit_cnt_nxt;
    free_r      <= free_nxt;
    free_idx_r  <= free_idx_nxt;
    removed_r   <= removed_nxt;
    out_tdata_r <= out_tdata_nxt;
    out_stat_r  <= out_stat_nxt;
  end

  // Occupancy never exceeds the table size.
  `KCPT_ASSERT(a_occ_bound, 1'b1, occ_r <= OCC_W'(TABLE_ENTRIES))
  // An accepted command always starts a scan in the next cycle.
  `KCPT_ASSERT_NXT(a_acc_scan, in_acc, state_r == ST_SCAN)
  // Memory writes during a scan come only from a purge.
  `KCPT_ASSERT(a_scan_wr_purge, ram_we && (state_r == ST_SCAN), cmd_r == CMD_PURGE)
  // Storing a new key raises the occupancy by exactly one.
  `KCPT_ASSERT_NXT(a_new_occ, (state_r == ST_FINISH) && fin_go && (fin_stat == STAT_NEW),
                   occ_r == $past(occ_r) + 1'b1)
  // A purge never frees more slots than are occupied.
  `KCPT_ASSERT(a_purge_bound, state_r == ST_FINISH, removed_r <= occ_r)

endmodule

FILE: sv/kcpt_ram.sv
// Generic simple dual-port RAM with one write port and one registered read port.
// No dependencies.
`timescale 1ns / 1ps

module kcpt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: bench/count_table_checker.sv
// Checker for the keyed count table with purge unit: predicts each result and compares.
// Depends on kcpt_pkg; instantiated by tb_top beside the unit.
`timescale 1ns / 1ps

module count_table_checker
  import kcpt_pkg::*;
#(
  parameter int SLOTS = TABLE_ENTRIES_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [95:0] in_tdata,
  input  logic        in_tuser,
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [47:0] out_tdata,
  input  logic [1:0]  out_tuser,
  output int          err_count,
  output int          pending,
  output int          results_checked,
  output int          drops_seen,
  output int          slots_purged
);

  typedef struct packed {
    status_t                 status;
    logic signed [VAL_W-1:0] total;
    logic [CNT_OUT_W-1:0]    removed;
    logic [CNT_OUT_W-1:0]    occupied;
  } table_result_t;

  localparam logic signed [VAL_W:0] SUM_MAX = 33'sh0_7FFF_FFFF;
  localparam logic signed [VAL_W:0] SUM_MIN = 33'sh1_8000_0000;

  // Shadow copy of the table.
  logic                    slot_valid [SLOTS];
  logic [KEY_W-1:0]        slot_key   [SLOTS];
  logic signed [VAL_W-1:0] slot_count [SLOTS];
  int                      occupied;
  table_result_t           expected_results [$];

  function automatic table_result_t table_step(cmd_t cmd, logic [KEY_W-1:0] key,
                                               logic signed [VAL_W-1:0] amt);
    table_result_t      r;
    int                 hit;
    int                 free_slot;
    int                 i;
    logic signed [VAL_W:0] sum;
    r = '0;
    hit = -1;
    free_slot = -1;
    if (cmd == CMD_ADD) begin
      for (i = 0; i < SLOTS; i++) begin
        if (slot_valid[i]) begin
          if (hit < 0 && slot_key[i] == key) hit = i;
        end else if (free_slot < 0) begin
          free_slot = i;
        end
      end
      if (hit >= 0) begin
        sum = {slot_count[hit][VAL_W-1], slot_count[hit]} + {amt[VAL_W-1], amt};
        if (sum > SUM_MAX) slot_count[hit] = SUM_MAX[VAL_W-1:0];
        else if (sum < SUM_MIN) slot_count[hit] = SUM_MIN[VAL_W-1:0];
        else slot_count[hit] = sum[VAL_W-1:0];
        r.status = STAT_ACCUM;
        r.total = slot_count[hit];
      end else if (free_slot >= 0) begin
        slot_valid[free_slot] = 1'b1;
        slot_key[free_slot] = key;
        slot_count[free_slot] = amt;
        occupied++;
        r.status = STAT_NEW;
        r.total = amt;
      end else begin
        r.status = STAT_FULL;
      end
    end else begin
      for (i = 0; i < SLOTS; i++) begin
        if (slot_valid[i] && slot_count[i] < amt) begin
          slot_valid[i] = 1'b0;
          r.removed++;
        end
      end
      occupied -= r.removed;
      r.status = STAT_PURGE;
    end
    r.occupied = occupied[CNT_OUT_W-1:0];
    return r;
  endfunction

  always @(posedge clk) begin : watch
    table_result_t got;
    table_result_t want;
    int            i;
    if (!rst_n) begin
      for (i = 0; i < SLOTS; i++) slot_valid[i] = 1'b0;
      occupied = 0;
      expected_results.delete();
      err_count = 0;
      results_checked = 0;
      drops_seen = 0;
      slots_purged = 0;
      pending <= 0;
    end else begin
      if (in_tvalid && in_tready)
        expected_results.push_back(table_step(cmd_t'(in_tuser), in_tdata[63:0],
                                              in_tdata[95:64]));
      if (out_tvalid && out_tready) begin
        got.status   = status_t'(out_tuser);
        got.total    = out_tdata[31:0];
        got.removed  = out_tdata[36:32];
        got.occupied = out_tdata[41:37];
        if (expected_results.size() == 0) begin
          err_count++;
          if (err_count <= 10)
            $display({"%0t: result with nothing expected: status %0d total %0d",
                      " removed %0d occupied %0d"},
                     $realtime, got.status, got.total, got.removed, got.occupied);
        end else begin
          want = expected_results.pop_front();
          results_checked++;
          if (want.status == STAT_FULL) drops_seen++;
          slots_purged += want.removed;
          if (got !== want) begin
            err_count++;
            if (err_count <= 10)
              $display({"%0t: mismatch: expected status %0d total %0d removed %0d occupied %0d,",
                        " got status %0d total %0d removed %0d occupied %0d"},
                       $realtime, want.status, want.total, want.removed, want.occupied,
                       got.status, got.total, got.removed, got.occupied);
          end
        end
      end
      pending <= expected_results.size();
    end
  end

endmodule

FILE: bench/tb_top.sv
// Top of the testbench for the keyed count table with purge unit: clock, reset, stimulus.
// Depends on kcpt_pkg, keyed_count_table_with_purge_unit and count_table_checker.
`timescale 1ns / 1ps

// The bench drives add and purge transactions into the unit and lets the checker
// predict and compare every result transaction. A short directed run covers an
// empty purge, saturation at both ends, filling the table, the table-full drop,
// reuse of the lowest free slot and a purge that frees the first slot. The random
// run then works in phases, each with its own pool of keys, so that keys are hit
// again, the table fills up and purges have something to free. Both the input and
// the result side idle at random in most phases; some phases run with no idling.
module tb_top;
  import kcpt_pkg::*;

  localparam int SLOTS        = 16;
  localparam int RANDOM_ITEMS = 2000;
  localparam int PHASES       = 8;
  // Twice the length of one command, scan and finish included, covers any work still in flight.
  localparam int DRAIN_CYCLES = 2 * (SLOTS + 3);
  // Bound on the length of the whole run; a clean run stays well below it.
  localparam int CYCLE_LIMIT  = 1_000_000;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [95:0] in_tdata = '0;
  logic        in_tuser = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b1;
  logic [47:0] out_tdata;
  logic [1:0]  out_tuser;

  // Idling is switched per phase; ready_hold counts down the current ready or stall run.
  logic        idle_on = 1'b1;
  int unsigned ready_hold = 0;
  int unsigned cycle_count = 0;

  int err_count;
  int pending;
  int results_checked;
  int drops_seen;
  int slots_purged;

  logic [KEY_W-1:0] key_pool [32];
  int unsigned      pool_size = 1;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  keyed_count_table_with_purge_unit #(
    .TABLE_ENTRIES(SLOTS)
  ) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser)
  );

  count_table_checker #(
    .SLOTS(SLOTS)
  ) u_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_tvalid      (in_tvalid),
    .in_tready      (in_tready),
    .in_tdata       (in_tdata),
    .in_tuser       (in_tuser),
    .out_tvalid     (out_tvalid),
    .out_tready     (out_tready),
    .out_tdata      (out_tdata),
    .out_tuser      (out_tuser),
    .err_count      (err_count),
    .pending        (pending),
    .results_checked(results_checked),
    .drops_seen     (drops_seen),
    .slots_purged   (slots_purged)
  );

  // Watchdog: a hung handshake ends the run as a failure.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("tb_top: done, errors");
      $finish;
    end
  end

  // Length of a stall: mostly short, now and then long.
  function automatic int unsigned stall_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) return $urandom_range(1, 3);
    if (r < 90) return $urandom_range(4, 12);
    return $urandom_range(13, 60);
  endfunction

  // Gap after an input transaction; often none at all.
  function automatic int unsigned send_gap();
    if ($urandom_range(0, 99) < 50) return 0;
    return stall_len();
  endfunction

  // The result side alternates ready runs and stalls while idling is on. Only
  // nonblocking writes, at most one per signal and edge, keep the order within a time step irrelevant.
  always @(posedge clk) begin
    if (ready_hold > 0) begin
      ready_hold <= ready_hold - 1;
    end else if (!out_tready) begin
      out_tready <= 1'b1;
      ready_hold <= $urandom_range(0, 30);
    end else if (idle_on) begin
      out_tready <= 1'b0;
      ready_hold <= stall_len() - 1;
    end
  end

  // Presents one transaction and waits for the edge that accepted it, with valid
  // still high; the task lowers valid only when a gap follows, so a back-to-back
  // transaction never sees valid lowered and raised in the same step.
  task automatic send_cmd(cmd_t cmd, logic [KEY_W-1:0] key, logic [VAL_W-1:0] val);
    int unsigned gap;
    in_tvalid <= 1'b1;
    in_tuser  <= cmd;
    in_tdata  <= {val, key};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    gap = idle_on ? send_gap() : 0;
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Amounts: mostly small of either sign, some full range, some near the limits so
  // that saturation comes up often.
  function automatic logic [VAL_W-1:0] pick_amount();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 65) return 32'($urandom_range(0, 200)) - 32'd100;
    if (r < 80) return $urandom;
    if (r < 90) return 32'h7FFF_FFFF - $urandom_range(0, 50);
    if (r < 98) return 32'h8000_0000 + $urandom_range(0, 50);
    return '0;
  endfunction

  // Thresholds: mostly in the range where counts wander, plus both extremes.
  function automatic logic [VAL_W-1:0] pick_threshold();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 32'($urandom_range(0, 240)) - 32'd120;
    if (r < 70) return $urandom;
    if (r < 80) return 32'h8000_0000;
    if (r < 88) return 32'h7FFF_FFFF;
    if (r < 94) return 32'h7FFF_FFF0 + $urandom_range(0, 14);
    return '0;
  endfunction

  // Keys mostly come from the phase's pool, so that entries are hit again; the rest
  // are fresh random keys that claim new slots or get dropped on a full table.
  function automatic logic [KEY_W-1:0] pick_key();
    if ($urandom_range(0, 99) < 85) return key_pool[$urandom_range(0, pool_size - 1)];
    return {$urandom, $urandom};
  endfunction

  initial begin : stimulus
    int unsigned purge_pct;
    int          per_phase;
    int          p;
    int          n;
    int          i;

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part. Purge on an empty table, with a key that must be ignored.
    send_cmd(CMD_PURGE, '1, 32'h0000_0000);
    // Slot 0 starts at the maximum and saturates; slot 1 at the minimum and saturates.
    send_cmd(CMD_ADD, '0, 32'h7FFF_FFFF);
    send_cmd(CMD_ADD, '0, 32'h0000_0001);
    send_cmd(CMD_ADD, '1, 32'h8000_0000);
    send_cmd(CMD_ADD, '1, 32'hFFFF_FFFF);
    send_cmd(CMD_ADD, '0, 32'hFFFF_FFFF);
    // Fill the remaining slots with counts 2 through 15.
    for (i = 2; i < SLOTS; i++) send_cmd(CMD_ADD, {32'(i), ~32'(i)}, 32'(i));
    // A new key on a full table is dropped; a known key still accumulates.
    send_cmd(CMD_ADD, 64'h0123_4567_89AB_CDEF, 32'h0000_0001);
    send_cmd(CMD_ADD, '1, 32'h7FFF_FFFF);
    // Nothing lies below the minimum threshold.
    send_cmd(CMD_PURGE, '0, 32'h8000_0000);
    // Frees slot 1 and the low counts; the next new key must take slot 1.
    send_cmd(CMD_PURGE, '0, 32'h0000_0005);
    send_cmd(CMD_ADD, 64'h0123_4567_89AB_CDEF, 32'h8000_0000);
    // The maximum threshold frees everything below it, slot 0 included.
    send_cmd(CMD_PURGE, '0, 32'h7FFF_FFFF);

    // Random part in phases. Small pools keep hitting the same entries; pools larger
    // than the table keep it full. Phases 0 and 5 run with no idling.
    per_phase = RANDOM_ITEMS / PHASES;
    for (p = 0; p < PHASES; p++) begin
      idle_on   <= (p != 0 && p != 5);
      pool_size = $urandom_range(4, 28);
      purge_pct = $urandom_range(3, 15);
      for (i = 0; i < 32; i++) key_pool[i] = {$urandom, $urandom};
      if ($urandom_range(0, 1) == 1) begin
        key_pool[0] = '0;
        key_pool[1] = '1;
      end
      for (n = 0; n < per_phase; n++) begin
        if ($urandom_range(0, 99) < purge_pct)
          send_cmd(CMD_PURGE, {$urandom, $urandom}, pick_threshold());
        else
          send_cmd(CMD_ADD, pick_key(), pick_amount());
      end
    end
    in_tvalid <= 1'b0;

    // The checker counts the last transaction only after its edge has passed, so
    // wait one edge before looking at the pending count. Then wait for every
    // expected result and leave room for anything stray.
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("tb_top: %0d results checked in %0d phases, %0d adds dropped on a full table,",
             results_checked, PHASES, drops_seen);
    $display("tb_top: %0d slots freed by purges, %0d mismatches", slots_purged, err_count);
    if (err_count == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("tb_top: done, errors");
    end
    $finish;
  end

endmodule
